// ===== rtl/core/neo_hookean_stress_tangent_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the neo-Hookean stress and tangent block
// Clocked implication checks with a common disable term.
// ----------------------------------------------------------------------------
`ifndef NEO_HOOKEAN_STRESS_TANGENT_MACROS_SVH
`define NEO_HOOKEAN_STRESS_TANGENT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NHST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nhst assertion failed");

// consequent must hold in the cycle after the antecedent
`define NHST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nhst assertion failed");

`endif

// ===== rtl/core/nhst_pkg.sv =====
// ----------------------------------------------------------------------------
// nhst_pkg
// Widths, latencies, register indexes and saturation helper of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package nhst_pkg;

    localparam int DEF_FRAC_BITS = 24;
    localparam int DW            = 32;
    localparam int JW            = 31;
    localparam int OW            = 48;
    localparam int PW            = 32;
    localparam int CFG_AW        = 8;

    localparam logic [CFG_AW-1:0] REG_FIRST_LAME = 8'd0;
    localparam logic [CFG_AW-1:0] REG_BASE_SHEAR = 8'd1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int LOG_STEPS = 32;
    localparam int LOG_LAT   = LOG_STEPS + 5;
    localparam int GRAM_CORE = 4;
    localparam int NUM_LAT   = 5;
    localparam int DIV_LAT   = OW + 2;

    localparam int BQ_W   = 50;
    localparam int KW     = 84;
    localparam int KMAG_W = KW - 1;
    localparam int TW     = 72;
    localparam int NCOMP  = 6;

    localparam int PAIR_ROW [NCOMP] = '{0, 1, 2, 0, 1, 0};
    localparam int PAIR_COL [NCOMP] = '{0, 1, 2, 1, 2, 2};

    localparam logic signed [OW-1:0] POS_SAT = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] NEG_SAT = {1'b1, {(OW-1){1'b0}}};
    localparam logic [TW-1:0] MAG_POS = {{(TW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic [TW-1:0] MAG_NEG = {{(TW-OW){1'b0}}, 1'b1, {(OW-1){1'b0}}};

    typedef logic signed [DW-1:0]   t_f;
    typedef logic signed [BQ_W-1:0] t_bq;
    typedef logic [KMAG_W-1:0]      t_kmag;
    typedef logic signed [OW-1:0]   t_out;

    function automatic t_out sat_mag(input logic neg, input logic [TW-1:0] mag);
        t_out r;
        if (!neg) begin
            if (mag > MAG_POS) r = POS_SAT;
            else r = $signed(mag[OW-1:0]);
        end else begin
            if (mag >= MAG_NEG) r = NEG_SAT;
            else r = -$signed(mag[OW-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nhst_ifs.sv =====
// ----------------------------------------------------------------------------
// nhst channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface nhst_in_if;
    logic                         valid;
    logic                         ready;
    nhst_pkg::t_f                 f_xx;
    nhst_pkg::t_f                 f_xy;
    nhst_pkg::t_f                 f_xz;
    nhst_pkg::t_f                 f_yx;
    nhst_pkg::t_f                 f_yy;
    nhst_pkg::t_f                 f_yz;
    nhst_pkg::t_f                 f_zx;
    nhst_pkg::t_f                 f_zy;
    nhst_pkg::t_f                 f_zz;
    logic [nhst_pkg::JW-1:0]      volume_ratio;

    modport source (output valid, f_xx, f_xy, f_xz, f_yx, f_yy, f_yz, f_zx, f_zy, f_zz,
                    volume_ratio, input ready);
    modport sink   (input valid, f_xx, f_xy, f_xz, f_yx, f_yy, f_yz, f_zx, f_zy, f_zz,
                    volume_ratio, output ready);
endinterface

interface nhst_out_if;
    logic           valid;
    logic           ready;
    nhst_pkg::t_out stress_xx;
    nhst_pkg::t_out stress_yy;
    nhst_pkg::t_out stress_zz;
    nhst_pkg::t_out stress_xy;
    nhst_pkg::t_out stress_yz;
    nhst_pkg::t_out stress_xz;
    nhst_pkg::t_out tangent_normal;
    nhst_pkg::t_out tangent_shear;

    modport source (output valid, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz,
                    stress_xz, tangent_normal, tangent_shear, input ready);
    modport sink   (input valid, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz,
                    stress_xz, tangent_normal, tangent_shear, output ready);
endinterface

interface nhst_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [nhst_pkg::CFG_AW-1:0] index;
    logic [nhst_pkg::PW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/neo_hookean_stress_tangent.sv =====
// ----------------------------------------------------------------------------
// neo_hookean_stress_tangent
// Compressible neo-Hookean material point: Cauchy stress and tangent moduli.
//
// i_item carries F (nine Q values) and J; o_result carries six stress parts
// and the two tangent terms; i_cfg writes lambda (index 0) and mu (index 1),
// always ready, to be written only while no item is in flight.
// From accept to result valid an item passes the log of J (32 squaring
// stages), the numerators and the one-bit-per-stage divider by J.
// Throughput is one item per cycle while o_result does not stall.
// All stages move on one enable, high when the output register is empty or
// being taken; while o_result stalls, every stage holds and i_item.ready is
// low, so nothing is lost or repeated.
// Reset clears the valid bits and both configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module neo_hookean_stress_tangent #(
    parameter int FRAC_BITS = nhst_pkg::DEF_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nhst_in_if.sink    i_item,
    nhst_out_if.source o_result,
    nhst_cfg_if.sink   i_cfg
);

    localparam int JD  = nhst_pkg::LOG_LAT + nhst_pkg::NUM_LAT;
    localparam int TOT = JD + nhst_pkg::DIV_LAT;
    localparam int DL  = nhst_pkg::DIV_LAT;

    logic [nhst_pkg::PW-1:0]     r_lam;
    logic [nhst_pkg::PW-1:0]     r_mu;
    logic [TOT-1:0]              r_vld;
    logic                        en;
    logic [nhst_pkg::JW-1:0]     j_eff;
    logic [nhst_pkg::JW-1:0]     r_jd  [JD];
    nhst_pkg::t_out              r_tnd [DL];
    nhst_pkg::t_out              r_tsd [DL];

    nhst_pkg::t_f                f_in  [9];
    logic signed [FRAC_BITS+5:0] lnj;
    nhst_pkg::t_bq               bq    [nhst_pkg::NCOMP];
    nhst_pkg::t_kmag             kmag  [nhst_pkg::NCOMP];
    logic [nhst_pkg::NCOMP-1:0]  kneg;
    nhst_pkg::t_out              tn;
    nhst_pkg::t_out              ts;
    nhst_pkg::t_out              q     [nhst_pkg::NCOMP];

    assign en             = !r_vld[TOT-1] || o_result.ready;
    assign i_item.ready   = en;
    assign i_cfg.ready    = 1'b1;
    assign j_eff          = (i_item.volume_ratio == '0) ? nhst_pkg::JW'(1)
                                                        : i_item.volume_ratio;

    assign f_in[0] = i_item.f_xx;
    assign f_in[1] = i_item.f_xy;
    assign f_in[2] = i_item.f_xz;
    assign f_in[3] = i_item.f_yx;
    assign f_in[4] = i_item.f_yy;
    assign f_in[5] = i_item.f_yz;
    assign f_in[6] = i_item.f_zx;
    assign f_in[7] = i_item.f_zy;
    assign f_in[8] = i_item.f_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam <= '0;
            r_mu  <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == nhst_pkg::REG_FIRST_LAME) r_lam <= i_cfg.data;
            if (i_cfg.index == nhst_pkg::REG_BASE_SHEAR) r_mu <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_jd[0]  <= j_eff;
            for (int i = 1; i < JD; i++) begin
                r_jd[i] <= r_jd[i-1];
            end
            r_tnd[0] <= tn;
            r_tsd[0] <= ts;
            for (int i = 1; i < DL; i++) begin
                r_tnd[i] <= r_tnd[i-1];
                r_tsd[i] <= r_tsd[i-1];
            end
        end
    end

    nhst_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .i_clk (i_clk),
        .i_en  (en),
        .i_j   (j_eff),
        .o_lnj (lnj)
    );

    nhst_gram #(.FRAC_BITS(FRAC_BITS)) u_gram (
        .i_clk (i_clk),
        .i_en  (en),
        .i_f   (f_in),
        .o_bq  (bq)
    );

    nhst_numer #(.FRAC_BITS(FRAC_BITS)) u_numer (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lnj  (lnj),
        .i_bq   (bq),
        .i_lam  (r_lam),
        .i_mu   (r_mu),
        .o_kmag (kmag),
        .o_kneg (kneg),
        .o_tn   (tn),
        .o_ts   (ts)
    );

    for (genvar c = 0; c < nhst_pkg::NCOMP; c++) begin : g_div
        nhst_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (kmag[c]),
            .i_neg (kneg[c]),
            .i_j   (r_jd[JD-1]),
            .o_q   (q[c])
        );
    end

    assign o_result.valid          = r_vld[TOT-1];
    assign o_result.stress_xx      = q[0];
    assign o_result.stress_yy      = q[1];
    assign o_result.stress_zz      = q[2];
    assign o_result.stress_xy      = q[3];
    assign o_result.stress_yz      = q[4];
    assign o_result.stress_xz      = q[5];
    assign o_result.tangent_normal = r_tnd[DL-1];
    assign o_result.tangent_shear  = r_tsd[DL-1];

`include "neo_hookean_stress_tangent_macros.svh"

    `NHST_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_item.valid && i_item.ready, r_vld[0])
    `NHST_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_result.valid && !o_result.ready, $stable(r_vld))
    `NHST_ASSERT_NOW(a_divisor_nonzero, i_clk, i_rst_n, r_vld[JD-1], r_jd[JD-1] != '0)

endmodule

`default_nettype wire

// ===== rtl/core/nhst_log.sv =====
// ----------------------------------------------------------------------------
// nhst_log
// Pipelined natural log of J: normalize, 32 squaring stages, scale by ln 2.
// ----------------------------------------------------------------------------
`default_nettype none

module nhst_log #(
    parameter int FRAC_BITS = nhst_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [nhst_pkg::JW-1:0]     i_j,
    output logic signed [FRAC_BITS+5:0] o_lnj
);

    localparam int NS  = nhst_pkg::LOG_STEPS;
    localparam int LNW = FRAC_BITS + 6;
    localparam int SW  = 64 - FRAC_BITS;
    localparam int PRW = 72;
    localparam logic [PRW-1:0] HALF = PRW'(1) << (SW - 1);

    logic [4:0]    k_c;
    logic [31:0]   m_c;
    logic [31:0]   r_m  [NS+1];
    logic [NS-1:0] r_fr [NS+1];
    logic [4:0]    r_k  [NS+1];

    logic signed [5:0]     hi_c;
    logic [63:0]           r_plo;
    logic signed [38:0]    r_phi;
    logic signed [PRW-1:0] r_sum;
    logic [PRW-1:0]        r_amag;
    logic                  r_neg;
    logic [LNW-1:0]        lm;

    always_comb begin
        k_c = '0;
        for (int b = 0; b < nhst_pkg::JW; b++) begin
            if (i_j[b]) k_c = 5'(b);
        end
        m_c = {1'b0, i_j} << (5'd31 - k_c);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= m_c;
            r_k[0]  <= k_c;
            r_fr[0] <= '0;
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;
        assign sq = 64'(r_m[s-1]) * 64'(r_m[s-1]);
        assign t  = sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s]  <= t[32] ? t[32:1] : t[31:0];
                r_fr[s] <= {r_fr[s-1][NS-2:0], t[32]};
                r_k[s]  <= r_k[s-1];
            end
        end
    end

    assign hi_c = $signed(6'(r_k[NS])) - $signed(6'(FRAC_BITS));
    assign lm   = LNW'(r_amag >> SW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo  <= 64'(r_fr[NS]) * 64'(nhst_pkg::LN2_Q32);
            r_phi  <= 39'(hi_c) * $signed({7'b0, nhst_pkg::LN2_Q32});
            r_sum  <= (PRW'(r_phi) <<< 32) + $signed({8'b0, r_plo});
            r_neg  <= r_sum[PRW-1];
            r_amag <= (r_sum[PRW-1] ? ~$unsigned(r_sum) : $unsigned(r_sum)) + HALF
                      + PRW'(r_sum[PRW-1]);
            o_lnj  <= r_neg ? -$signed(lm) : $signed(lm);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nhst_gram.sv =====
// ----------------------------------------------------------------------------
// nhst_gram
// Six components of B = F*F^T, rounded to Q format, aligned to the log path.
// ----------------------------------------------------------------------------
`default_nettype none

module nhst_gram #(
    parameter int FRAC_BITS = nhst_pkg::DEF_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  nhst_pkg::t_f  i_f  [9],
    output nhst_pkg::t_bq o_bq [nhst_pkg::NCOMP]
);

    localparam int DLY = nhst_pkg::LOG_LAT - nhst_pkg::GRAM_CORE;
    localparam int AW  = 66;
    localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

    for (genvar c = 0; c < nhst_pkg::NCOMP; c++) begin : g_c
        localparam int R = nhst_pkg::PAIR_ROW[c];
        localparam int C = nhst_pkg::PAIR_COL[c];

        logic signed [63:0]   r_p [3];
        logic signed [AW-1:0] r_acc;
        logic [AW-1:0]        r_mag;
        logic                 r_neg;
        logic [AW-1:0]        sh;
        nhst_pkg::t_bq        r_dl [DLY+1];

        assign sh      = r_mag >> FRAC_BITS;
        assign o_bq[c] = r_dl[DLY];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_p[k] <= 64'(i_f[R*3+k]) * 64'(i_f[C*3+k]);
                end
                r_acc   <= AW'(r_p[0]) + AW'(r_p[1]) + AW'(r_p[2]);
                r_neg   <= r_acc[AW-1];
                r_mag   <= (r_acc[AW-1] ? ~$unsigned(r_acc) : $unsigned(r_acc)) + HALF
                           + AW'(r_acc[AW-1]);
                r_dl[0] <= r_neg ? -$signed(nhst_pkg::BQ_W'(sh))
                                 : $signed(nhst_pkg::BQ_W'(sh));
                for (int d = 1; d <= DLY; d++) begin
                    r_dl[d] <= r_dl[d-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nhst_numer.sv =====
// ----------------------------------------------------------------------------
// nhst_numer
// Stress numerators as sign and magnitude, and the two saturated tangent terms.
// ----------------------------------------------------------------------------
`default_nettype none

module nhst_numer #(
    parameter int FRAC_BITS = nhst_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [FRAC_BITS+5:0]  i_lnj,
    input  nhst_pkg::t_bq                i_bq [nhst_pkg::NCOMP],
    input  logic [nhst_pkg::PW-1:0]      i_lam,
    input  logic [nhst_pkg::PW-1:0]      i_mu,
    output nhst_pkg::t_kmag              o_kmag [nhst_pkg::NCOMP],
    output logic [nhst_pkg::NCOMP-1:0]   o_kneg,
    output nhst_pkg::t_out               o_tn,
    output nhst_pkg::t_out               o_ts
);

    localparam int BQ_W = nhst_pkg::BQ_W;
    localparam int KW   = nhst_pkg::KW;
    localparam int TW   = nhst_pkg::TW;
    localparam int LLW  = FRAC_BITS + 39;
    localparam int DL   = 25;
    localparam logic signed [BQ_W-1:0] ONE = BQ_W'(1) << FRAC_BITS;
    localparam logic [TW-1:0] HALF_T = TW'(1) << (FRAC_BITS - 1);

    logic signed [LLW-1:0] r_lamln;
    logic signed [LLW-1:0] r_lamln2;
    logic signed [LLW-1:0] r_lamln3;
    logic [33:0]           r_c;
    logic signed [TW-1:0]  r_t;
    logic signed [TW-1:0]  r_n;
    logic [TW-1:0]         r_tm;
    logic [TW-1:0]         r_nm;
    logic                  r_tneg;
    logic                  r_nneg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lamln  <= LLW'(i_lnj) * $signed({1'b0, i_lam});
            r_lamln2 <= r_lamln;
            r_c      <= 34'(i_lam) + 34'({i_mu, 1'b0});
            r_lamln3 <= r_lamln2;
            r_t      <= $signed(TW'({i_mu, {FRAC_BITS{1'b0}}})) - TW'(r_lamln2);
            r_n      <= $signed(TW'({r_c, {FRAC_BITS{1'b0}}})) - (TW'(r_lamln2) <<< 1);
            r_tneg   <= r_t[TW-1];
            r_tm     <= (r_t[TW-1] ? ~$unsigned(r_t) : $unsigned(r_t)) + HALF_T
                        + TW'(r_t[TW-1]);
            r_nneg   <= r_n[TW-1];
            r_nm     <= (r_n[TW-1] ? ~$unsigned(r_n) : $unsigned(r_n)) + HALF_T
                        + TW'(r_n[TW-1]);
            o_ts     <= nhst_pkg::sat_mag(r_tneg, r_tm >> FRAC_BITS);
            o_tn     <= nhst_pkg::sat_mag(r_nneg, r_nm >> FRAC_BITS);
        end
    end

    for (genvar c = 0; c < nhst_pkg::NCOMP; c++) begin : g_c
        localparam bit DIAG = (nhst_pkg::PAIR_ROW[c] == nhst_pkg::PAIR_COL[c]);

        logic signed [BQ_W-1:0] r_d;
        logic [56:0]            r_pl;
        logic signed [57:0]     r_ph;
        logic signed [KW-1:0]   r_pm;
        logic signed [KW-1:0]   r_k;
        nhst_pkg::t_kmag        r_kmag;
        logic                   r_kneg;

        assign o_kmag[c] = r_kmag;
        assign o_kneg[c] = r_kneg;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d    <= DIAG ? i_bq[c] - ONE : i_bq[c];
                r_pl   <= 57'(r_d[DL-1:0]) * 57'(i_mu);
                r_ph   <= 58'($signed(r_d[BQ_W-1:DL])) * $signed({26'b0, i_mu});
                r_pm   <= (KW'(r_ph) <<< DL) + $signed(KW'(r_pl));
                r_k    <= DIAG ? r_pm + KW'(r_lamln3) : r_pm;
                r_kneg <= r_k[KW-1];
                r_kmag <= nhst_pkg::KMAG_W'((r_k[KW-1] ? ~$unsigned(r_k) : $unsigned(r_k))
                          + KW'(r_k[KW-1]));
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nhst_div.sv =====
// ----------------------------------------------------------------------------
// nhst_div
// Pipelined restoring divide of a numerator magnitude by J, one quotient bit
// per stage, rounded half away from zero and saturated to the output range.
// ----------------------------------------------------------------------------
`default_nettype none

module nhst_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  nhst_pkg::t_kmag         i_mag,
    input  logic                    i_neg,
    input  logic [nhst_pkg::JW-1:0] i_j,
    output nhst_pkg::t_out          o_q
);

    localparam int OW   = nhst_pkg::OW;
    localparam int JW   = nhst_pkg::JW;
    localparam int NS   = OW;
    localparam int TOPW = nhst_pkg::KMAG_W - OW;

    logic [JW-1:0] r_rem [NS+1];
    logic [OW-1:0] r_x   [NS+1];
    logic [JW-1:0] r_d   [NS+1];
    logic          r_ovf [NS+1];
    logic          r_sg  [NS+1];

    logic          rnd;
    logic [OW:0]   q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= JW'(i_mag[nhst_pkg::KMAG_W-1:OW]);
            r_x[0]   <= i_mag[OW-1:0];
            r_d[0]   <= i_j;
            r_ovf[0] <= i_mag[nhst_pkg::KMAG_W-1:OW] >= TOPW'(i_j);
            r_sg[0]  <= i_neg;
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_st
        logic [JW:0] rr;
        logic        ge;
        assign rr = {r_rem[s-1], r_x[s-1][OW-1]};
        assign ge = rr >= {1'b0, r_d[s-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? JW'(rr - {1'b0, r_d[s-1]}) : rr[JW-1:0];
                r_x[s]   <= {r_x[s-1][OW-2:0], ge};
                r_d[s]   <= r_d[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_sg[s]  <= r_sg[s-1];
            end
        end
    end

    assign rnd = {r_rem[NS], 1'b0} >= {1'b0, r_d[NS]};
    assign q   = {1'b0, r_x[NS]} + (OW+1)'(rnd);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[NS]) begin
                o_q <= r_sg[NS] ? nhst_pkg::NEG_SAT : nhst_pkg::POS_SAT;
            end else begin
                o_q <= nhst_pkg::sat_mag(r_sg[NS], nhst_pkg::TW'(q));
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for neo_hookean_stress_tangent
// Streams deformation gradients and determinants through the block under
// random idling on both sides, predicts each stress and tangent result with
// a wide-integer model, and compares every result field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nhst_pkg::*;

    localparam int FB = DEF_FRAC_BITS;
    localparam int LATENCY = 92;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        t_out v [8];
    } t_expect;

    logic i_clk;
    logic i_rst_n;

    nhst_in_if  item_ch ();
    nhst_out_if result_ch ();
    nhst_cfg_if cfg_ch ();

    neo_hookean_stress_tangent #(.FRAC_BITS(FB)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    logic [31:0] lame_q;
    logic [31:0] shear_q;
    t_expect     expected_results [$];
    int          mismatches = 0;
    bit          failed = 1'b0;
    bit          idle_off;
    int          stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] log_of_volume(input logic [30:0] jv);
        int k;
        logic [63:0] m;
        logic [31:0] frac;
        logic signed [63:0] l2;
        logic signed [127:0] p;
        logic [127:0] mag;
        k = 30;
        while (k > 0 && jv[k] == 1'b0) k--;
        m = 64'(jv) << (31 - k);
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = (64'(signed'(k)) - FB) * 64'sh1_0000_0000 + $signed({32'd0, frac});
        p = 128'(l2) * $signed({96'd0, LN2_Q32});
        mag = p[127] ? -p : p;
        mag = (mag + (128'd1 << (63 - FB))) >> (64 - FB);
        return p[127] ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    function automatic t_out clip48(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF) return POS_SAT;
        if (v < -128'sh8000_0000_0000) return NEG_SAT;
        return v[47:0];
    endfunction

    function automatic logic signed [127:0] round_shift(input logic signed [127:0] v);
        logic [127:0] mag;
        mag = v[127] ? -v : v;
        mag = (mag + (128'd1 << (FB - 1))) >> FB;
        return v[127] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic t_expect predict_material(input t_f f [9], input logic [30:0] jraw);
        t_expect e;
        logic [30:0] jv;
        logic signed [127:0] lnj, lamln, acc, bq, kk, t, n, one, lam, mu, jd;
        logic [127:0] mag, q, r;
        int rows [6] = '{0, 1, 2, 0, 1, 0};
        int cols [6] = '{0, 1, 2, 1, 2, 2};
        jv = (jraw == 0) ? 31'd1 : jraw;
        jd = $signed({97'd0, jv});
        lam = $signed({96'd0, lame_q});
        mu = $signed({96'd0, shear_q});
        one = 128'sd1 <<< FB;
        lnj = 128'(log_of_volume(jv));
        lamln = lnj * lam;
        for (int p = 0; p < 6; p++) begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += 128'(f[rows[p]*3+c]) * 128'(f[cols[p]*3+c]);
            bq = round_shift(acc);
            kk = (rows[p] == cols[p]) ? (bq - one) * mu + lamln : bq * mu;
            mag = kk[127] ? -kk : kk;
            q = mag / jd;
            r = mag % jd;
            if (2 * r >= jd) q = q + 1;
            e.v[p] = clip48(kk[127] ? -$signed(q) : $signed(q));
        end
        t = mu * one - lamln;
        n = lam * one + t + t;
        e.v[6] = clip48(round_shift(n));
        e.v[7] = clip48(round_shift(t));
        return e;
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_FIRST_LAME) lame_q = val;
        else if (idx == REG_BASE_SHEAR) shear_q = val;
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_material(input logic [31:0] lam, input logic [31:0] mu);
        drain_results();
        write_reg(REG_FIRST_LAME, lam);
        write_reg(REG_BASE_SHEAR, mu);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input t_f f [9], input logic [30:0] jv);
        while (!idle_off && $urandom_range(99) < 32) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.f_xx <= f[0]; item_ch.f_xy <= f[1]; item_ch.f_xz <= f[2];
        item_ch.f_yx <= f[3]; item_ch.f_yy <= f[4]; item_ch.f_yz <= f[5];
        item_ch.f_zx <= f[6]; item_ch.f_zy <= f[7]; item_ch.f_zz <= f[8];
        item_ch.volume_ratio <= jv;
        do @(posedge i_clk); while (!item_ch.ready);
        expected_results.push_back(predict_material(f, jv));
    endtask

    task automatic end_burst();
        item_ch.valid <= 1'b0;
    endtask

    function automatic t_f near_unit(input int spread);
        return (32'sd1 <<< FB) + $signed(32'($urandom_range(2 * spread) - spread));
    endfunction

    task automatic send_gradient(input bit wild);
        t_f f [9];
        logic [30:0] jv;
        for (int i = 0; i < 9; i++) begin
            if (wild) f[i] = $urandom;
            else if (i % 4 == 0) f[i] = near_unit(1 << (FB - 2));
            else f[i] = $signed(32'($urandom_range(1 << (FB - 1)))) - (1 << (FB - 2));
        end
        case ($urandom_range(3))
            0: jv = 31'($urandom);
            1: jv = 31'($urandom_range(255));
            default: jv = 31'((32'd1 << FB) + $urandom_range(1 << (FB - 1)) - (1 << (FB - 2)));
        endcase
        send_item(f, jv);
    endtask

    task automatic test_directed_extremes();
        t_f f [9];
        t_f corner [4] = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd0, -32'sd1};
        logic [30:0] js [5] = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd1 << FB, 31'h4000_0000};
        idle_off = 1'b1;
        set_material(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 5; j++) begin
                for (int i = 0; i < 9; i++) f[i] = (i % 2 == j % 2) ? corner[c] : corner[3 - c];
                send_item(f, js[j]);
            end
        for (int i = 0; i < 9; i++) f[i] = (i % 4 == 0) ? (32'sd1 <<< FB) : 32'sd0;
        send_item(f, 31'd1 << FB);
        send_item(f, 31'd0);
        end_burst();
    endtask

    task automatic test_settings_sweep();
        logic [31:0] mats [4][2] = '{'{32'd0, 32'd0}, '{32'd1 << FB, 32'd1 << (FB - 1)},
                                    '{32'hFFFF_FFFF, 32'd0}, '{32'd0, 32'hFFFF_FFFF}};
        for (int s = 0; s < 4; s++) begin
            set_material(mats[s][0], mats[s][1]);
            idle_off = (s == 1);
            for (int n = 0; n < 50; n++) send_gradient($urandom_range(9) == 0);
            end_burst();
        end
    endtask

    task automatic test_random_stream();
        for (int s = 0; s < 6; s++) begin
            set_material($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << (FB + 4)),
                         $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << (FB + 4)));
            idle_off = (s == 2);
            for (int n = 0; n < 75; n++) send_gradient($urandom_range(4) == 0);
            end_burst();
        end
        @(posedge i_clk);
        for (int n = 0; n < 180; n++) send_gradient(1'b1);
        end_burst();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= idle_off || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        t_expect e;
        t_out got [8];
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.stress_xx, result_ch.stress_yy, result_ch.stress_zz,
                    result_ch.stress_xy, result_ch.stress_yz, result_ch.stress_xz,
                    result_ch.tangent_normal, result_ch.tangent_shear};
            if (expected_results.size() == 0) begin
                failed = 1'b1;
                $display("unexpected result item");
            end else begin
                e = expected_results.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got[i] !== e.v[i]) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d: expected %0d got %0d", i, e.v[i], got[i]);
                    end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        idle_off = 1'b0;
        lame_q = '0;
        shear_q = '0;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.f_xx = '0; item_ch.f_xy = '0; item_ch.f_xz = '0;
        item_ch.f_yx = '0; item_ch.f_yy = '0; item_ch.f_yz = '0;
        item_ch.f_zx = '0; item_ch.f_zy = '0; item_ch.f_zz = '0;
        item_ch.volume_ratio = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_settings_sweep();
        test_random_stream();
        drain_results();
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/nhst_pkg.sv
rtl/core/nhst_ifs.sv
rtl/core/nhst_log.sv
rtl/core/nhst_gram.sv
rtl/core/nhst_numer.sv
rtl/core/nhst_div.sv
rtl/core/neo_hookean_stress_tangent.sv
tb/sv/tb_top.sv
